@@ sv/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg: shared types for the midpoint ellipse rasterizer
// Datapath command and status types that pass between the controller and
// the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

    // Width of one output coordinate (two's complement, modulo 2^12)
    localparam int OUT_W = 12;

    // Operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,      // rx * rx
        MUL_RY_RY,      // ry * ry (y holds ry right after load)
        MUL_RX2_RY,     // rx^2 * ry
        MUL_X_X1,       // x * (x + 1)
        MUL_RY2_P,      // ry^2 * previous product
        MUL_YM1_SQ,     // (y - 1) * (y - 1)
        MUL_RX2_P,      // rx^2 * previous product
        MUL_RX2_RY2     // rx^2 * ry^2
    } t_mul_sel;

    // Writeback of the registered product or quarter-term correction
    typedef enum logic [3:0] {
        WB_NONE,
        WB_RX2,         // rx^2 <= product
        WB_RY2,         // ry^2 <= product
        WB_SLOPE_D,     // py <= 2*product, d <= ry^2 - product
        WB_D_SET,       // d <= product
        WB_D_ADD,       // d <= d + product
        WB_D_SUB,       // d <= d - product
        WB_QTR_RX2,     // d <= trunc(d + rx^2/4)
        WB_QTR_RY2      // d <= trunc(d + ry^2/4)
    } t_wb_sel;

    typedef struct packed {
        logic     load;     // latch a new ellipse from the input beat
        t_mul_sel mul_sel;
        t_wb_sel  wb_sel;
        logic     step1;    // emit points, advance in region 1
        logic     step2;    // emit points, advance in region 2
    } t_dp_cmd;

    typedef struct packed {
        logic slope_lt;     // px < py, signed
        logic last_step;    // y - 1 is negative
    } t_dp_status;

endpackage

@@ sv/mer_dpath.sv @@
// ----------------------------------------------------------------------------
// mer_dpath: ellipse rasterizer datapath
// Holds the center, offsets, squared radii, slope terms and decision value.
// One shared registered multiplier serves the setup sequences; the point
// step and the output register are updated under controller command.
// ----------------------------------------------------------------------------
module mer_dpath #(
    parameter int COORD_BITS = 10
) (
    input  logic                          i_clk,
    input  mer_pkg::t_dp_cmd              i_cmd,
    input  logic [COORD_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS-1:0]         i_center_y,
    input  logic [COORD_BITS-1:0]         i_radius_x,
    input  logic [COORD_BITS-1:0]         i_radius_y,
    output mer_pkg::t_dp_status           o_status,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt0_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt0_y,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt1_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt1_y,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt2_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt2_y,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt3_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt3_y,
    output logic                          o_last_points
);
    import mer_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int X_W     = C + 2;
    localparam int SQ_W    = 2 * C;
    localparam int SLOPE_W = 3 * C + 4;
    localparam int DEC_W   = 4 * C + 8;
    localparam int MUL_W   = 2 * C + 4;
    localparam int SUM_W   = ((X_W > OUT_W) ? X_W : OUT_W) + 1;

    // Ellipse state
    logic [C-1:0]              r_cx, r_cy, r_rx;
    logic [X_W-1:0]            r_x;
    logic signed [X_W-1:0]     r_y;
    logic [SQ_W-1:0]           r_rx2, r_ry2;
    logic signed [SLOPE_W-1:0] r_px, r_py;
    logic signed [DEC_W-1:0]   r_d;
    logic signed [DEC_W-1:0]   r_p;

    // Output payload
    logic [OUT_W-1:0] r_p0x, r_p0y, r_p1x, r_p2y;
    logic             r_last;

    // Common derived values
    logic signed [X_W-1:0]     w_ym1;
    logic [X_W:0]              w_x1;
    logic signed [SLOPE_W-1:0] w_two_rx2, w_two_ry2;
    logic signed [SLOPE_W-1:0] w_px_n, w_py_n;
    logic signed [DEC_W-1:0]   w_rx2_d, w_ry2_d, w_px_n_d, w_py_n_d;

    assign w_ym1     = r_y - X_W'(1);
    assign w_x1      = {1'b0, r_x} + (X_W+1)'(1);
    assign w_two_rx2 = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, r_rx2, 1'b0});
    assign w_two_ry2 = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, r_ry2, 1'b0});
    assign w_px_n    = r_px + w_two_ry2;
    assign w_py_n    = r_py - w_two_rx2;
    assign w_rx2_d   = $signed({{(DEC_W-SQ_W){1'b0}}, r_rx2});
    assign w_ry2_d   = $signed({{(DEC_W-SQ_W){1'b0}}, r_ry2});
    assign w_px_n_d  = $signed({{(DEC_W-SLOPE_W){w_px_n[SLOPE_W-1]}}, w_px_n});
    assign w_py_n_d  = $signed({{(DEC_W-SLOPE_W){w_py_n[SLOPE_W-1]}}, w_py_n});

    assign o_status.slope_lt  = (r_px < r_py);
    assign o_status.last_step = w_ym1[X_W-1];

    // Multiplier operand select
    logic signed [MUL_W-1:0] w_ma, w_mb;
    logic signed [MUL_W-1:0] w_rx_m, w_y_m, w_ym1_m, w_x_m, w_x1_m;
    logic signed [MUL_W-1:0] w_rx2_m, w_ry2_m, w_p_m;

    assign w_rx_m  = $signed({{(MUL_W-C){1'b0}}, r_rx});
    assign w_y_m   = $signed({{(MUL_W-X_W){r_y[X_W-1]}}, r_y});
    assign w_ym1_m = $signed({{(MUL_W-X_W){w_ym1[X_W-1]}}, w_ym1});
    assign w_x_m   = $signed({{(MUL_W-X_W){1'b0}}, r_x});
    assign w_x1_m  = $signed({{(MUL_W-X_W-1){1'b0}}, w_x1});
    assign w_rx2_m = $signed({{(MUL_W-SQ_W){1'b0}}, r_rx2});
    assign w_ry2_m = $signed({{(MUL_W-SQ_W){1'b0}}, r_ry2});
    assign w_p_m   = r_p[MUL_W-1:0];

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_RX_RX: begin
                w_ma = w_rx_m;  w_mb = w_rx_m;
            end
            MUL_RY_RY: begin
                w_ma = w_y_m;   w_mb = w_y_m;
            end
            MUL_RX2_RY: begin
                w_ma = w_rx2_m; w_mb = w_y_m;
            end
            MUL_X_X1: begin
                w_ma = w_x_m;   w_mb = w_x1_m;
            end
            MUL_RY2_P: begin
                w_ma = w_ry2_m; w_mb = w_p_m;
            end
            MUL_YM1_SQ: begin
                w_ma = w_ym1_m; w_mb = w_ym1_m;
            end
            MUL_RX2_P: begin
                w_ma = w_rx2_m; w_mb = w_p_m;
            end
            MUL_RX2_RY2: begin
                w_ma = w_rx2_m; w_mb = w_ry2_m;
            end
            default: begin
                w_ma = '0;      w_mb = '0;
            end
        endcase
    end

    // Registered product
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_p <= w_ma * w_mb;
        end
    end

    // Quarter-term add, truncated toward zero
    logic [SQ_W-1:0]         w_qv;
    logic signed [DEC_W-1:0] w_qs, w_qs1, w_qtr;

    assign w_qv  = (i_cmd.wb_sel == WB_QTR_RX2) ? r_rx2 : r_ry2;
    assign w_qs  = r_d + $signed({{(DEC_W-SQ_W+2){1'b0}}, w_qv[SQ_W-1:2]});
    assign w_qs1 = w_qs + DEC_W'(1);
    assign w_qtr = ((w_qv[1:0] != 2'b00) && w_qs[DEC_W-1]) ? w_qs1 : w_qs;

    // Decision updates for one point step
    logic signed [DEC_W-1:0] w_d_r1, w_d_r2;
    logic                    w_d_neg, w_d_pos;

    assign w_d_neg = r_d[DEC_W-1];
    assign w_d_pos = !r_d[DEC_W-1] && (r_d != '0);
    assign w_d_r1  = w_d_neg ? (r_d + w_ry2_d + w_px_n_d)
                             : (r_d + w_ry2_d + w_px_n_d - w_py_n_d);
    assign w_d_r2  = w_d_pos ? (r_d + w_rx2_d - w_py_n_d)
                             : (r_d + w_rx2_d - w_py_n_d + w_px_n_d);

    // Ellipse state update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_rx <= i_radius_x;
            r_x  <= '0;
            r_y  <= $signed({2'b00, i_radius_y});
            r_px <= '0;
        end else if (i_cmd.step1) begin
            r_x  <= r_x + X_W'(1);
            r_px <= w_px_n;
            r_d  <= w_d_r1;
            if (!w_d_neg) begin
                r_y  <= w_ym1;
                r_py <= w_py_n;
            end
        end else if (i_cmd.step2) begin
            r_y  <= w_ym1;
            r_py <= w_py_n;
            r_d  <= w_d_r2;
            if (!w_d_pos) begin
                r_x  <= r_x + X_W'(1);
                r_px <= w_px_n;
            end
        end else begin
            case (i_cmd.wb_sel)
                WB_RX2:     r_rx2 <= r_p[SQ_W-1:0];
                WB_RY2:     r_ry2 <= r_p[SQ_W-1:0];
                WB_SLOPE_D: begin
                    r_py <= $signed({r_p[SLOPE_W-2:0], 1'b0});
                    r_d  <= w_ry2_d - r_p;
                end
                WB_D_SET:   r_d <= r_p;
                WB_D_ADD:   r_d <= r_d + r_p;
                WB_D_SUB:   r_d <= r_d - r_p;
                WB_QTR_RX2,
                WB_QTR_RY2: r_d <= w_qtr;
                default: ;
            endcase
        end
    end

    // Point sums, taken modulo 2^OUT_W
    logic [SUM_W-1:0] w_cx_s, w_cy_s, w_x_s, w_y_s;
    logic [SUM_W-1:0] w_xp, w_xm, w_yp, w_yn;

    assign w_cx_s = {{(SUM_W-C){1'b0}}, r_cx};
    assign w_cy_s = {{(SUM_W-C){1'b0}}, r_cy};
    assign w_x_s  = {{(SUM_W-X_W){1'b0}}, r_x};
    assign w_y_s  = {{(SUM_W-X_W){r_y[X_W-1]}}, r_y};
    assign w_xp   = w_cx_s + w_x_s;
    assign w_xm   = w_cx_s - w_x_s;
    assign w_yp   = w_cy_s + w_y_s;
    assign w_yn   = w_cy_s - w_y_s;

    // Output register, loaded with the current point set on each step
    always_ff @(posedge i_clk) begin
        if (i_cmd.step1 || i_cmd.step2) begin
            r_p0x  <= w_xp[OUT_W-1:0];
            r_p1x  <= w_xm[OUT_W-1:0];
            r_p0y  <= w_yp[OUT_W-1:0];
            r_p2y  <= w_yn[OUT_W-1:0];
            r_last <= i_cmd.step2 && w_ym1[X_W-1];
        end
    end

    assign o_pt0_x       = $signed(r_p0x);
    assign o_pt0_y       = $signed(r_p0y);
    assign o_pt1_x       = $signed(r_p1x);
    assign o_pt1_y       = $signed(r_p0y);
    assign o_pt2_x       = $signed(r_p0x);
    assign o_pt2_y       = $signed(r_p2y);
    assign o_pt3_x       = $signed(r_p1x);
    assign o_pt3_y       = $signed(r_p2y);
    assign o_last_points = r_last;

endmodule

@@ sv/mer_ctrl.sv @@
// ----------------------------------------------------------------------------
// mer_ctrl: ellipse rasterizer controller
// Sequences setup of a new ellipse and of region 2 through the shared
// multiplier, takes input beats and owns the output valid flag.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_start_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  mer_pkg::t_dp_status   i_status,
    output mer_pkg::t_dp_cmd      o_cmd
);
    import mer_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_SLOPE,
        ST_D1_SET,
        ST_D1_QTR,
        ST_R1_STEP,
        ST_R1_CHECK,
        ST_R1_WAIT,
        ST_N_XX,
        ST_N_RYP,
        ST_N_YSQ,
        ST_N_RXP,
        ST_N_RR,
        ST_N_SUB,
        ST_N_QTR,
        ST_R2_STEP,
        ST_R2_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_owed, n_owed;       // start beat still owes its first point set
    logic   r_out_valid, n_out_valid;
    logic   w_accept, w_slot_free, w_emit;

    assign w_accept    = i_valid && !o_stall;
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_emit      = o_cmd.step1 || o_cmd.step2;
    assign o_valid     = r_out_valid;

    // Input is taken only while waiting for the next beat
    always_comb begin
        o_stall = !((r_state == ST_IDLE) || (r_state == ST_R1_WAIT) ||
                    (r_state == ST_R2_WAIT));
    end

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_owed        = r_owed;
        o_cmd.load    = 1'b0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.wb_sel  = WB_NONE;
        o_cmd.step1   = 1'b0;
        o_cmd.step2   = 1'b0;

        unique case (r_state)
            ST_IDLE, ST_R1_WAIT, ST_R2_WAIT: begin
                if (w_accept) begin
                    if (i_start_req) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_SQ_RX;
                    end else if (r_state == ST_R1_WAIT) begin
                        n_state = ST_R1_STEP;
                    end else if (r_state == ST_R2_WAIT) begin
                        n_state = ST_R2_STEP;
                    end
                end
            end
            ST_SQ_RX: begin
                o_cmd.mul_sel = MUL_RX_RX;
                n_state       = ST_SQ_RY;
            end
            ST_SQ_RY: begin
                o_cmd.wb_sel  = WB_RX2;
                o_cmd.mul_sel = MUL_RY_RY;
                n_state       = ST_SLOPE;
            end
            ST_SLOPE: begin
                o_cmd.wb_sel  = WB_RY2;
                o_cmd.mul_sel = MUL_RX2_RY;
                n_state       = ST_D1_SET;
            end
            ST_D1_SET: begin
                o_cmd.wb_sel = WB_SLOPE_D;
                n_state      = ST_D1_QTR;
            end
            ST_D1_QTR: begin
                o_cmd.wb_sel = WB_QTR_RX2;
                if (i_status.slope_lt) begin
                    n_state = ST_R1_STEP;
                end else begin
                    n_owed  = 1'b1;
                    n_state = ST_N_XX;
                end
            end
            ST_R1_STEP: begin
                if (w_slot_free) begin
                    o_cmd.step1 = 1'b1;
                    n_state     = ST_R1_CHECK;
                end
            end
            ST_R1_CHECK: begin
                if (i_status.slope_lt) begin
                    n_state = ST_R1_WAIT;
                end else begin
                    n_owed  = 1'b0;
                    n_state = ST_N_XX;
                end
            end
            // Region 2 decision value: ry^2(x^2+x) + rx^2(y-1)^2 - rx^2 ry^2
            ST_N_XX: begin
                o_cmd.mul_sel = MUL_X_X1;
                n_state       = ST_N_RYP;
            end
            ST_N_RYP: begin
                o_cmd.mul_sel = MUL_RY2_P;
                n_state       = ST_N_YSQ;
            end
            ST_N_YSQ: begin
                o_cmd.wb_sel  = WB_D_SET;
                o_cmd.mul_sel = MUL_YM1_SQ;
                n_state       = ST_N_RXP;
            end
            ST_N_RXP: begin
                o_cmd.mul_sel = MUL_RX2_P;
                n_state       = ST_N_RR;
            end
            ST_N_RR: begin
                o_cmd.wb_sel  = WB_D_ADD;
                o_cmd.mul_sel = MUL_RX2_RY2;
                n_state       = ST_N_SUB;
            end
            ST_N_SUB: begin
                o_cmd.wb_sel = WB_D_SUB;
                n_state      = ST_N_QTR;
            end
            ST_N_QTR: begin
                o_cmd.wb_sel = WB_QTR_RY2;
                n_state      = r_owed ? ST_R2_STEP : ST_R2_WAIT;
            end
            ST_R2_STEP: begin
                if (w_slot_free) begin
                    o_cmd.step2 = 1'b1;
                    n_state     = i_status.last_step ? ST_IDLE : ST_R2_WAIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid: set on a step, cleared once the beat is taken
    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_owed      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_owed      <= n_owed;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ sv/midpoint_ellipse_rasterizer.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: midpoint ellipse point generator
// A start beat loads center and semi-axes and yields the first point set;
// each further beat yields the next four symmetric points, the final set
// flagged by o_last_points. Beats while idle yield nothing. A start beat
// runs setup (rx^2, ry^2 and rx^2*ry through one registered multiplier)
// before its point set, and also rebuilds the region-2 decision value when
// the ellipse begins directly in region 2. A region-1 advance beat passes
// accept, step and slope compare; at the step that crosses into region 2
// the region-2 decision value is rebuilt with five multiplies on the same
// unit. A region-2 advance beat passes accept and step. A point set can wait
// in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_start_req,
    input  logic [COORD_BITS-1:0]            i_center_x,
    input  logic [COORD_BITS-1:0]            i_center_y,
    input  logic [COORD_BITS-1:0]            i_radius_x,
    input  logic [COORD_BITS-1:0]            i_radius_y,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt0_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt0_y,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt1_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt1_y,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt2_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt2_y,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt3_x,
    output logic signed [mer_pkg::OUT_W-1:0] o_pt3_y,
    output logic                             o_last_points
);
    import mer_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Controller
    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_start_req (i_start_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath
    mer_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .o_status      (w_status),
        .o_pt0_x       (o_pt0_x),
        .o_pt0_y       (o_pt0_y),
        .o_pt1_x       (o_pt1_x),
        .o_pt1_y       (o_pt1_y),
        .o_pt2_x       (o_pt2_x),
        .o_pt2_y       (o_pt2_y),
        .o_pt3_x       (o_pt3_x),
        .o_pt3_y       (o_pt3_y),
        .o_last_points (o_last_points)
    );

    // Load and the two step kinds never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.step1, w_cmd.step2}))
        else $error("load and step commands overlap");

    // A step only overwrites the output register once its beat is gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step1 || w_cmd.step2) |-> (!o_valid || !i_stall))
        else $error("point set overwritten before it was taken");

    // Region 1 never ends an ellipse
    a_r1_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step1 |=> (o_valid && !o_last_points))
        else $error("region 1 step flagged as last");

endmodule

@@ sim/mer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_checker: point-set scoreboard for the midpoint ellipse rasterizer
// Watches the input and output channels of the rasterizer. Every accepted
// input beat is run through a cycle-free model of the midpoint ellipse walk
// (64-bit wrapping arithmetic, exact quarter terms truncated toward zero).
// Every accepted output beat is compared field by field against the oldest
// predicted point set.
// ----------------------------------------------------------------------------
module mer_checker #(
    parameter int COORD_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel of the block
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_start_req,
    input  logic [COORD_BITS-1:0]            i_center_x,
    input  logic [COORD_BITS-1:0]            i_center_y,
    input  logic [COORD_BITS-1:0]            i_radius_x,
    input  logic [COORD_BITS-1:0]            i_radius_y,
    // output channel of the block
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt0_x,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt0_y,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt1_x,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt1_y,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt2_x,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt2_y,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt3_x,
    input  logic signed [mer_pkg::OUT_W-1:0] i_pt3_y,
    input  logic                             i_last_points,
    // run status
    output int                               o_errors,
    output int                               o_point_sets,
    output int                               o_final_sets,
    output int                               o_pending
);

    localparam int OW = mer_pkg::OUT_W;

    typedef struct {
        logic [OW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
        logic          last;
    } t_point_set;

    t_point_set expected_sets[$];

    // walk state, kept at 64 bits so wraparound matches the spec
    bit          drawing;
    bit          region_two;
    logic [63:0] ctr_x, ctr_y;
    logic [63:0] x_off, y_off;
    logic [63:0] rx_sq, ry_sq;
    logic [63:0] px, py;
    logic [63:0] dval;

    // trunc(base + v/4), rounding toward zero
    function automatic logic [63:0] add_quarter_trunc(input logic [63:0] base,
                                                      input logic [63:0] v);
        logic [63:0] s;
        s = base + (v >> 2);
        if (v[1:0] != 2'd0 && s[63])
            s = s + 64'd1;
        return s;
    endfunction

    // region-2 decision value, rebuilt once from the current (x, y)
    task automatic set_region_two();
        logic [63:0] xo, ym1, acc;
        xo  = x_off;
        ym1 = y_off - 64'd1;
        acc = ry_sq * (xo * xo + xo) + rx_sq * ym1 * ym1 - rx_sq * ry_sq;
        dval = add_quarter_trunc(acc, ry_sq);
        region_two = 1'b1;
    endtask

    task automatic clear_walk();
        drawing    = 1'b0;
        region_two = 1'b0;
        ctr_x = '0; ctr_y = '0;
        x_off = '0; y_off = '0;
        rx_sq = '0; ry_sq = '0;
        px    = '0; py    = '0;
        dval  = '0;
    endtask

    // advance the walk by one input beat, queue the point set it yields
    task automatic predict_point_set(input logic start,
                                     input logic [COORD_BITS-1:0] cx,
                                     input logic [COORD_BITS-1:0] cy,
                                     input logic [COORD_BITS-1:0] rx,
                                     input logic [COORD_BITS-1:0] ry);
        t_point_set  ps;
        logic [63:0] rx64, ry64, x0, y0;
        bit          last;
        if (start) begin
            rx64  = 64'(rx);
            ry64  = 64'(ry);
            ctr_x = 64'(cx);
            ctr_y = 64'(cy);
            rx_sq = rx64 * rx64;
            ry_sq = ry64 * ry64;
            x_off = '0;
            y_off = ry64;
            px    = '0;
            py    = 64'd2 * rx_sq * ry64;
            dval  = add_quarter_trunc(ry_sq - rx_sq * ry64, rx_sq);
            region_two = 1'b0;
            drawing    = 1'b1;
            // flat ellipse skips region 1
            if (!($signed(px) < $signed(py)))
                set_region_two();
        end
        if (!drawing)
            return;

        x0   = x_off;
        y0   = y_off;
        last = 1'b0;
        if (!region_two) begin
            x_off = x_off + 64'd1;
            px    = px + 64'd2 * ry_sq;
            if (dval[63]) begin
                dval = dval + ry_sq + px;
            end else begin
                y_off = y_off - 64'd1;
                py    = py - 64'd2 * rx_sq;
                dval  = dval + ry_sq + px - py;
            end
            if (!($signed(px) < $signed(py)))
                set_region_two();
        end else begin
            y_off = y_off - 64'd1;
            py    = py - 64'd2 * rx_sq;
            if (!dval[63] && dval != 64'd0) begin
                dval = dval + rx_sq - py;
            end else begin
                x_off = x_off + 64'd1;
                px    = px + 64'd2 * ry_sq;
                dval  = dval + rx_sq - py + px;
            end
            // y went below zero: this set closes the ellipse
            if (y_off[63]) begin
                last       = 1'b1;
                drawing    = 1'b0;
                region_two = 1'b0;
            end
        end

        ps.p0x  = OW'(ctr_x + x0);
        ps.p0y  = OW'(ctr_y + y0);
        ps.p1x  = OW'(ctr_x - x0);
        ps.p1y  = OW'(ctr_y + y0);
        ps.p2x  = OW'(ctr_x + x0);
        ps.p2y  = OW'(ctr_y - y0);
        ps.p3x  = OW'(ctr_x - x0);
        ps.p3y  = OW'(ctr_y - y0);
        ps.last = last;
        expected_sets.push_back(ps);
    endtask

    function automatic void check_field(input string name, input logic [OW-1:0] want,
                                        input logic [OW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            o_errors++;
        end
    endfunction

    // scoreboard: inputs feed the walk, outputs are checked in order
    always @(posedge i_clk) begin
        t_point_set want;
        if (!i_rst_n) begin
            clear_walk();
            expected_sets.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_point_set(i_start_req, i_center_x, i_center_y,
                                  i_radius_x, i_radius_y);
            if (i_out_valid && !i_out_stall) begin
                o_point_sets++;
                if (i_last_points === 1'b1)
                    o_final_sets++;
                if (expected_sets.size() == 0) begin
                    $error("point set with no beat to account for it");
                    o_errors++;
                end else begin
                    want = expected_sets.pop_front();
                    check_field("pt0_x", want.p0x, i_pt0_x);
                    check_field("pt0_y", want.p0y, i_pt0_y);
                    check_field("pt1_x", want.p1x, i_pt1_x);
                    check_field("pt1_y", want.p1y, i_pt1_y);
                    check_field("pt2_x", want.p2x, i_pt2_x);
                    check_field("pt2_y", want.p2y, i_pt2_y);
                    check_field("pt3_x", want.p3x, i_pt3_x);
                    check_field("pt3_y", want.p3y, i_pt3_y);
                    check_field("last_points", OW'(want.last), OW'(i_last_points));
                end
            end
        end
        o_pending = expected_sets.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the midpoint ellipse rasterizer
// Drives start and advance beats: a directed set of corner ellipses (flat,
// zero radius, widest radii, restarts, coordinate wrap) followed by random
// ellipses, mostly walked to their final point set, some abandoned by a
// restart, with stray advance beats mixed in. Both channels idle at random
// in the first two of three phases. mer_checker predicts and compares; this
// module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COORD_BITS = 10;
    localparam int OW         = mer_pkg::OUT_W;
    localparam int ITEM_GOAL  = 1050;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_start_req = 1'b0;
    logic [COORD_BITS-1:0] i_center_x  = '0;
    logic [COORD_BITS-1:0] i_center_y  = '0;
    logic [COORD_BITS-1:0] i_radius_x  = '0;
    logic [COORD_BITS-1:0] i_radius_y  = '0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic signed [OW-1:0]  o_pt0_x, o_pt0_y, o_pt1_x, o_pt1_y;
    logic signed [OW-1:0]  o_pt2_x, o_pt2_y, o_pt3_x, o_pt3_y;
    logic                  o_last_points;

    int n_errors, n_point_sets, n_final_sets, n_pending;
    int items_sent   = 0;
    int n_ellipses   = 0;
    int src_idle_pct = 9;
    int rcv_stall_pct = 57;

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    midpoint_ellipse_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_start_req  (i_start_req),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius_x   (i_radius_x),
        .i_radius_y   (i_radius_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pt0_x      (o_pt0_x),
        .o_pt0_y      (o_pt0_y),
        .o_pt1_x      (o_pt1_x),
        .o_pt1_y      (o_pt1_y),
        .o_pt2_x      (o_pt2_x),
        .o_pt2_y      (o_pt2_y),
        .o_pt3_x      (o_pt3_x),
        .o_pt3_y      (o_pt3_y),
        .o_last_points(o_last_points)
    );

    mer_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_start_req  (i_start_req),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius_x   (i_radius_x),
        .i_radius_y   (i_radius_y),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_pt0_x      (o_pt0_x),
        .i_pt0_y      (o_pt0_y),
        .i_pt1_x      (o_pt1_x),
        .i_pt1_y      (o_pt1_y),
        .i_pt2_x      (o_pt2_x),
        .i_pt2_y      (o_pt2_y),
        .i_pt3_x      (o_pt3_x),
        .i_pt3_y      (o_pt3_y),
        .i_last_points(o_last_points),
        .o_errors     (n_errors),
        .o_point_sets (n_point_sets),
        .o_final_sets (n_final_sets),
        .o_pending    (n_pending)
    );

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // one beat: optional sender gap, then hold until accepted
    task automatic send_beat(input logic start,
                             input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy,
                             input logic [COORD_BITS-1:0] rx,
                             input logic [COORD_BITS-1:0] ry);
        int gap;
        gap = 0;
        // idling phases: sender light / receiver heavy, swapped, then none
        if (items_sent < ITEM_GOAL / 3) begin
            src_idle_pct  = 9;
            rcv_stall_pct = 57;
        end else if (items_sent < 2 * ITEM_GOAL / 3) begin
            src_idle_pct  = 57;
            rcv_stall_pct = 9;
        end else begin
            src_idle_pct  = 0;
            rcv_stall_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_start_req <= start;
        i_center_x  <= cx;
        i_center_y  <= cy;
        i_radius_x  <= rx;
        i_radius_y  <= ry;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // advance beat; the coordinate fields carry noise the block ignores
    task automatic send_advance();
        send_beat(1'b0, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    // start an ellipse and follow it with a number of advance beats
    task automatic draw_ellipse(input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [COORD_BITS-1:0] rx,
                                input logic [COORD_BITS-1:0] ry,
                                input int n_adv);
        send_beat(1'b1, cx, cy, rx, ry);
        n_ellipses++;
        repeat (n_adv) send_advance();
    endtask

    // mostly small radii, some medium, a few anywhere in range
    function automatic logic [COORD_BITS-1:0] pick_radius();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return COORD_BITS'($urandom_range(15, 0));
        if (roll < 90)
            return COORD_BITS'($urandom_range(100, 16));
        return COORD_BITS'($urandom_range(1023, 0));
    endfunction

    // stimulus
    initial begin
        logic [COORD_BITS-1:0] rx, ry;
        int n_adv;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: advance while idle, degenerate and extreme ellipses
        send_advance();
        draw_ellipse(10'd0, 10'd0, 10'd0, 10'd0, 1);        // single point, then idle
        draw_ellipse(10'd1023, 10'd1023, 10'd5, 10'd0, 0);  // flat, ry = 0
        draw_ellipse(10'd512, 10'd0, 10'd0, 10'd3, 4);      // rx = 0, region 2 only
        draw_ellipse(10'd0, 10'd1023, 10'd1023, 10'd1023, 2); // widest, restarted
        draw_ellipse(10'd1023, 10'd0, 10'd1023, 10'd1, 2);  // long region 1, restarted
        draw_ellipse(10'd5, 10'd5, 10'd1, 10'd1023, 3);     // crosses to region 2 at once
        draw_ellipse(10'd100, 10'd100, 10'd2, 10'd1, 5);    // full walk past the end

        // random ellipses, mostly walked to completion
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(9) == 0) begin
                // stray advance beats
                repeat ($urandom_range(3, 1)) send_advance();
            end else begin
                rx = pick_radius();
                ry = pick_radius();
                if (rx <= 100 && ry <= 100 && $urandom_range(3) != 0)
                    n_adv = int'(rx) + int'(ry) + 4;
                else
                    n_adv = $urandom_range(30, 0);
                draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), rx, ry, n_adv);
            end
        end
        i_valid <= 1'b0;

        // drain, then allow for the longest setup latency
        while (n_pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d ellipses, %0d point sets checked, %0d of them final.",
                 n_ellipses, n_point_sets, n_final_sets);
        $display("Idling: receiver-heavy, then sender-heavy, then back-to-back beats.");
        if (n_errors == 0)
            $display("** midpoint_ellipse_rasterizer: PASSED **");
        else
            $display("** midpoint_ellipse_rasterizer: FAILED **");
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("** midpoint_ellipse_rasterizer: FAILED **");
        $finish;
    end

endmodule
